// ----- sv/lru_pkg.sv -----
package lru_pkg;

  localparam int NUM_BLOCKS_DEFAULT = 16;

  localparam int CMD_W = 2;
  localparam int IDX_W = 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_ACCESS     = 2'd0,
    CMD_REPLACE    = 2'd1,
    CMD_INVALIDATE = 2'd2
  } cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [IDX_W-1:0] block_index;
  } req_t;

  typedef struct packed {
    logic             victim_valid;
    logic [IDX_W-1:0] victim_index;
    logic             victim_was_free;
  } result_t;

endpackage

// ----- sv/lru_replacement_policy_top.sv -----
// Least-recently-used replacement policy over NUM_BLOCKS cache blocks. Each request is an
// access (moves the block to the most-recent end), a replace (returns the lowest-numbered
// free block, or evicts the least-recent one) or an invalidate-all, and every request
// returns exactly one result; only replace results carry a victim. The block takes one
// request per clock while out_ready lets results drain: each request is first held in
// an input register, then one pass through the recency list compare-and-shift logic
// updates the state and loads the result register. A result that waits on
// out_ready stalls intake only once the input register is also occupied.
module lru_replacement_policy_top #(
  parameter int NUM_BLOCKS = lru_pkg::NUM_BLOCKS_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [lru_pkg::CMD_W-1:0] command,
  input  logic [lru_pkg::IDX_W-1:0] block_index,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      victim_valid,
  output logic [lru_pkg::IDX_W-1:0] victim_index,
  output logic                      victim_was_free
);

  lru_pkg::req_t    in_req;
  lru_pkg::req_t    req;
  lru_pkg::result_t result;
  lru_pkg::result_t result_q;
  logic             req_valid;
  logic             can_load;
  logic             advance;

  assign in_req.command     = command;
  assign in_req.block_index = block_index;
  assign advance            = req_valid && can_load;

  lru_in_reg u_in_reg (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_req    (in_req),
    .req_valid (req_valid),
    .req       (req),
    .advance   (advance)
  );

  lru_core #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .req     (req),
    .result  (result)
  );

  lru_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .load       (advance),
    .can_load   (can_load),
    .result_in  (result),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .result_out (result_q)
  );

  assign victim_valid    = result_q.victim_valid;
  assign victim_index    = result_q.victim_index;
  assign victim_was_free = result_q.victim_was_free;

endmodule

// ----- sv/lru_in_reg.sv -----
module lru_in_reg (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  lru_pkg::req_t in_req,
  output logic          req_valid,
  output lru_pkg::req_t req,
  input  logic          advance
);

  logic full;

  // A new request may enter when the register is empty or the held one leaves in the same cycle.
  assign in_ready  = !full || advance;
  assign req_valid = full;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (in_valid && in_ready) begin
      full <= 1'b1;
    end else if (advance) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req <= in_req;
    end
  end

endmodule

// ----- sv/lru_core.sv -----
module lru_core #(
  parameter int NUM_BLOCKS = lru_pkg::NUM_BLOCKS_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  lru_pkg::req_t    req,
  output lru_pkg::result_t result
);

  localparam int IW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int LW = $clog2(NUM_BLOCKS + 1);
  localparam int CW = 7;

  logic [NUM_BLOCKS-1:0] valid_map;
  logic [NUM_BLOCKS-1:0] valid_map_next;
  logic [IW-1:0]         recency_order [NUM_BLOCKS];
  logic [IW-1:0]         recency_order_next [NUM_BLOCKS];
  logic [IW-1:0]         shifted [NUM_BLOCKS];
  logic [LW-1:0]         order_length;
  logic [LW-1:0]         order_length_next;
  logic [LW-1:0]         last_pos;

  logic [CW-1:0]         idx_wide;
  logic                  idx_in_range;
  logic [NUM_BLOCKS-1:0] hit_vec;
  logic [NUM_BLOCKS-1:0] from_pos;
  logic                  any_hit;
  logic                  any_free;
  logic [IW-1:0]         free_idx;
  logic                  do_move;
  logic                  do_append;
  logic                  do_clear;
  logic                  is_evict;
  logic [IW-1:0]         moved_blk;

  assign idx_wide     = CW'(req.block_index);
  assign idx_in_range = idx_wide < CW'(NUM_BLOCKS);
  assign last_pos     = order_length - LW'(1);
  assign any_free     = ~&valid_map;
  assign any_hit      = |hit_vec;

  // Each block sits in the list at most once, so at most one entry hits.
  always_comb begin
    for (int i = 0; i < NUM_BLOCKS; i++) begin
      hit_vec[i] = (LW'(i) < order_length) && (CW'(recency_order[i]) == idx_wide)
                   && idx_in_range;
    end
  end

  always_comb begin
    free_idx = '0;
    for (int i = NUM_BLOCKS - 1; i >= 0; i--) begin
      if (!valid_map[i]) begin
        free_idx = IW'(i);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_BLOCKS - 1; i++) begin
      shifted[i] = recency_order[i + 1];
    end
    shifted[NUM_BLOCKS-1] = recency_order[NUM_BLOCKS-1];
  end

  always_comb begin
    do_move   = 1'b0;
    do_append = 1'b0;
    do_clear  = 1'b0;
    is_evict  = 1'b0;
    moved_blk = IW'(req.block_index);
    result    = '0;
    case (req.command)
      lru_pkg::CMD_ACCESS: begin
        do_move = any_hit;
      end
      lru_pkg::CMD_REPLACE: begin
        if (any_free) begin
          do_append              = order_length < LW'(NUM_BLOCKS);
          result.victim_valid    = 1'b1;
          result.victim_index    = lru_pkg::IDX_W'(free_idx);
          result.victim_was_free = 1'b1;
        end else if (order_length != '0) begin
          do_move                = 1'b1;
          is_evict               = 1'b1;
          moved_blk              = recency_order[0];
          result.victim_valid    = 1'b1;
          result.victim_index    = lru_pkg::IDX_W'(recency_order[0]);
          result.victim_was_free = 1'b0;
        end
      end
      lru_pkg::CMD_INVALIDATE: begin
        do_clear = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Eviction moves the head, so every entry from position zero takes part.
  always_comb begin
    from_pos[0] = hit_vec[0] || is_evict;
    for (int i = 1; i < NUM_BLOCKS; i++) begin
      from_pos[i] = from_pos[i-1] || hit_vec[i];
    end
  end

  always_comb begin
    valid_map_next    = valid_map;
    order_length_next = order_length;
    for (int i = 0; i < NUM_BLOCKS; i++) begin
      recency_order_next[i] = recency_order[i];
      if (do_move && from_pos[i]) begin
        if (LW'(i) == last_pos) begin
          recency_order_next[i] = moved_blk;
        end else if (LW'(i) < last_pos) begin
          recency_order_next[i] = shifted[i];
        end
      end
      if (do_append && (LW'(i) == order_length)) begin
        recency_order_next[i] = free_idx;
      end
    end
    if (do_append || (req.command == lru_pkg::CMD_REPLACE && any_free)) begin
      valid_map_next[free_idx] = 1'b1;
    end
    if (do_append) begin
      order_length_next = order_length + LW'(1);
    end
    if (do_clear) begin
      valid_map_next    = '0;
      order_length_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_map    <= '0;
      order_length <= '0;
    end else if (advance) begin
      valid_map    <= valid_map_next;
      order_length <= order_length_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i < NUM_BLOCKS; i++) begin
        recency_order[i] <= recency_order_next[i];
      end
    end
  end

`ifndef SYNTH
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    order_length <= LW'(NUM_BLOCKS))
    else $error("recency list longer than the block count");

  a_list_matches_valid: assert property (@(posedge clk) disable iff (rst)
    $countones(valid_map) == int'(order_length))
    else $error("recency list length differs from number of valid blocks");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    advance && do_clear |=> order_length == '0 && valid_map == '0)
    else $error("invalidate left state behind");

  a_free_grows: assert property (@(posedge clk) disable iff (rst)
    advance && result.victim_valid && result.victim_was_free
    |=> order_length == $past(order_length) + LW'(1))
    else $error("free replacement did not extend the list");

  a_evict_keeps: assert property (@(posedge clk) disable iff (rst)
    advance && is_evict |=> order_length == $past(order_length))
    else $error("eviction changed the list length");
`endif

endmodule

// ----- sv/lru_out_reg.sv -----
module lru_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  output logic             can_load,
  input  lru_pkg::result_t result_in,
  output logic             out_valid,
  input  logic             out_ready,
  output lru_pkg::result_t result_out
);

  assign can_load = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_out <= result_in;
    end
  end

endmodule
